[sv/tlad_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlad_pkg
// Shared constants, types and helpers for the two-link arm dynamics block:
// quarter-wave sine table, binary-angle sine lookup, Q16.16 saturation.
// ----------------------------------------------------------------------------
package tlad_pkg;

  // Quarter-wave sine table geometry
  localparam int unsigned SINE_DEPTH = 256;
  localparam int unsigned IDX_W      = $clog2(SINE_DEPTH + 1);
  localparam int unsigned PROD_W     = 15 + IDX_W;

  localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;
  localparam longint unsigned ONE_Q30     = 64'd1073741824;

  // Table entries are unsigned Q1.16, 0 .. 65536
  typedef logic [SINE_DEPTH:0][16:0] sine_lut_t;

  // Number of register stages in the datapath
  localparam int unsigned NSTG = 7;

  // Configuration register map
  localparam int unsigned CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_LINK2_LENGTH,
    CFG_LINK1_MASS,
    CFG_LINK2_MASS,
    CFG_LINK1_COM_OFFSET,
    CFG_GRAVITY
  } cfg_idx_t;

  localparam logic        [15:0] RST_LINK2_LENGTH     = 16'd17897;
  localparam logic        [15:0] RST_LINK1_MASS       = 16'd2659;
  localparam logic        [15:0] RST_LINK2_MASS       = 16'd2205;
  localparam logic signed [15:0] RST_LINK1_COM_OFFSET = -16'sd1476;
  localparam logic        [15:0] RST_GRAVITY          = 16'd2509;

  // Width of the signed values handed to the saturation stage
  localparam int unsigned SAT_IN_W = 40;

  // Build the table at elaboration: odd Taylor series through x^11 in Q2.30
  function automatic sine_lut_t build_sine_lut();
    sine_lut_t       lut;
    longint unsigned x;
    longint unsigned x2;
    longint unsigned t;
    longint unsigned s;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      x  = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
      x2 = (x * x) >> 30;
      t  = ONE_Q30 - x2 / 110;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
      t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
      s  = (x * t) >> 30;
      s  = (s + 64'd8192) >> 14;
      if (s > 64'd65536) begin
        s = 64'd65536;
      end
      lut[k] = s[16:0];
    end
    return lut;
  endfunction

  localparam sine_lut_t SINE_LUT = build_sine_lut();

  // Sine of a 16-bit binary angle, signed Q1.16
  function automatic logic signed [17:0] sin_bam(input logic [15:0] ang);
    logic        [1:0]        quad;
    logic        [14:0]       pos;
    logic        [PROD_W-1:0] prod;
    logic        [IDX_W-1:0]  idx;
    logic signed [17:0]       mag;
    quad = ang[15:14];
    // mirror the position in the odd quadrants
    pos  = quad[0] ? 15'(15'd16384 - {1'b0, ang[13:0]}) : {1'b0, ang[13:0]};
    prod = PROD_W'(pos) * PROD_W'(SINE_DEPTH);
    idx  = prod[14 +: IDX_W];
    mag  = {1'b0, SINE_LUT[idx]};
    return quad[1] ? -mag : mag;
  endfunction

  // Clamp a signed value to signed 32 bits
  function automatic logic [31:0] sat32(input logic signed [SAT_IN_W-1:0] v);
    logic [31:0] res;
    if (v[SAT_IN_W-1:31] == '0 || v[SAT_IN_W-1:31] == '1) begin
      res = v[31:0];
    end else if (v[SAT_IN_W-1]) begin
      res = 32'h8000_0000;
    end else begin
      res = 32'h7FFF_FFFF;
    end
    return res;
  endfunction

endpackage

[sv/two_link_arm_dynamics_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// two_link_arm_dynamics_top
// Diagonal mass-matrix entries and Coriolis/gravity torques of a planar
// two-link arm, all signed Q16.16 with saturation, in a seven-stage pipeline.
// ----------------------------------------------------------------------------
//  channel  | handshake          | payload
//  ---------+--------------------+-------------------------------------------
//  input    | in_valid/in_ready  | joint2_angle, joint1_rate, joint2_rate
//  result   | out_valid/out_ready| inertia_00, inertia_11, torque_joint1/2
//  config   | cfg_we             | cfg_addr, cfg_wdata (16 bit)
//
//  A result passes through seven register stages, st1 to st7, before it is
//  offered at the output; one item can enter every cycle while the output
//  is not stalled. The depth is set by the multiplier chain: each stage
//  holds one layer of multiplies of up to about 35 x 32 bits, or wide adds.
//  Every stage advances when it is empty or the stage after it advances, so
//  bubbles close up under a stalled output and nothing is lost or repeated.
//  Synchronous reset clears the stage valid bits and loads the register
//  reset values; the sine table is constant logic and needs no fill.
// ----------------------------------------------------------------------------
module two_link_arm_dynamics_top (
  input  logic                                clk,
  input  logic                                rst_n,
  // input channel
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic        [15:0]                  in_joint2_angle,
  input  logic signed [15:0]                  in_joint1_rate,
  input  logic signed [15:0]                  in_joint2_rate,
  // result channel
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [31:0]                  out_inertia_00,
  output logic signed [31:0]                  out_inertia_11,
  output logic signed [31:0]                  out_torque_joint1,
  output logic signed [31:0]                  out_torque_joint2,
  // configuration
  input  logic                                cfg_we,
  input  logic        [tlad_pkg::CFG_IDX_W-1:0] cfg_addr,
  input  logic        [15:0]                  cfg_wdata
);
  import tlad_pkg::*;

  // Stage payloads
  typedef struct packed {
    logic signed [17:0] sin2;
    logic signed [17:0] cos2;
    logic signed [17:0] cos1;
    logic signed [31:0] w12;
    logic signed [31:0] w11;
    logic        [31:0] ll;
    logic        [31:0] lg;
    logic        [30:0] xx;
  } st1_t;

  typedef struct packed {
    logic signed [17:0] sin2;
    logic signed [17:0] cos2;
    logic signed [17:0] cos1;
    logic signed [31:0] w12;
    logic signed [31:0] w11;
    logic        [47:0] aex;
    logic        [47:0] lgm;
    logic        [46:0] t2;
  } st2_t;

  typedef struct packed {
    logic        [57:0] t1;
    logic signed [58:0] bs;
    logic signed [58:0] grav;
    logic        [46:0] t2;
    logic        [31:0] i11;
    logic signed [31:0] w12;
    logic signed [31:0] w11;
  } st3_t;

  typedef struct packed {
    logic        [31:0] i00;
    logic        [31:0] i11;
    logic signed [33:0] b24;
    logic signed [58:0] grav;
    logic signed [31:0] w12;
    logic signed [31:0] w11;
  } st4_t;

  typedef struct packed {
    logic        [31:0] i00;
    logic        [31:0] i11;
    logic signed [63:0] p2;
    logic signed [63:0] p3;
    logic signed [58:0] grav;
  } st5_t;

  typedef struct packed {
    logic        [31:0]         i00;
    logic        [31:0]         i11;
    logic signed [SAT_IN_W-1:0] r2;
    logic signed [63:0]         sum3;
  } st6_t;

  typedef struct packed {
    logic [31:0] i00;
    logic [31:0] i11;
    logic [31:0] tq1;
    logic [31:0] tq2;
  } st7_t;

  // Configuration registers
  logic        [15:0] link2_length_r, link2_length_nxt;
  logic        [15:0] link1_mass_r, link1_mass_nxt;
  logic        [15:0] link2_mass_r, link2_mass_nxt;
  logic signed [15:0] link1_com_offset_r, link1_com_offset_nxt;
  logic        [15:0] gravity_r, gravity_nxt;

  // Pipeline control
  logic [NSTG-1:0] vld_r, vld_nxt;
  logic [NSTG-1:0] stg_en;

  // Pipeline data
  st1_t st1_r, st1_nxt;
  st2_t st2_r, st2_nxt;
  st3_t st3_r, st3_nxt;
  st4_t st4_r, st4_nxt;
  st5_t st5_r, st5_nxt;
  st6_t st6_r, st6_nxt;
  st7_t st7_r, st7_nxt;

  // Intermediates
  logic        [15:0] ang_dbl;
  logic signed [31:0] xx_full;
  logic        [39:0] a_r;
  logic        [17:0] cos2_bias;
  logic        [48:0] i11_sum;
  logic        [58:0] i00_sum;
  logic        [58:0] bs_rnd;
  logic        [63:0] r2_rnd;
  logic        [63:0] r3_rnd;

  // --------------------------------------------------------------------------
  // Configuration write port
  // --------------------------------------------------------------------------
  always_comb begin
    link2_length_nxt     = link2_length_r;
    link1_mass_nxt       = link1_mass_r;
    link2_mass_nxt       = link2_mass_r;
    link1_com_offset_nxt = link1_com_offset_r;
    gravity_nxt          = gravity_r;
    if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_addr))
        CFG_LINK2_LENGTH:     link2_length_nxt     = cfg_wdata;
        CFG_LINK1_MASS:       link1_mass_nxt       = cfg_wdata;
        CFG_LINK2_MASS:       link2_mass_nxt       = cfg_wdata;
        CFG_LINK1_COM_OFFSET: link1_com_offset_nxt = cfg_wdata;
        CFG_GRAVITY:          gravity_nxt          = cfg_wdata;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link2_length_r     <= RST_LINK2_LENGTH;
      link1_mass_r       <= RST_LINK1_MASS;
      link2_mass_r       <= RST_LINK2_MASS;
      link1_com_offset_r <= RST_LINK1_COM_OFFSET;
      gravity_r          <= RST_GRAVITY;
    end else begin
      link2_length_r     <= link2_length_nxt;
      link1_mass_r       <= link1_mass_nxt;
      link2_mass_r       <= link2_mass_nxt;
      link1_com_offset_r <= link1_com_offset_nxt;
      gravity_r          <= gravity_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage enables: advance when empty or when the next stage advances
  // --------------------------------------------------------------------------
  always_comb begin
    stg_en[NSTG-1] = !vld_r[NSTG-1] || out_ready;
    for (int k = NSTG - 2; k >= 0; k--) begin
      stg_en[k] = !vld_r[k] || stg_en[k+1];
    end
  end

  assign in_ready = stg_en[0];

  always_comb begin
    for (int k = 0; k < NSTG; k++) begin
      if (stg_en[k]) begin
        vld_nxt[k] = (k == 0) ? in_valid : vld_r[(k == 0) ? 0 : k - 1];
      end else begin
        vld_nxt[k] = vld_r[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1: sine/cosine lookups, rate products, configuration squares
  // --------------------------------------------------------------------------
  always_comb begin
    ang_dbl      = {in_joint2_angle[14:0], 1'b0};
    xx_full      = 32'(link1_com_offset_r) * 32'(link1_com_offset_r);
    st1_nxt.sin2 = sin_bam(ang_dbl);
    st1_nxt.cos2 = sin_bam(ang_dbl + 16'd16384);
    st1_nxt.cos1 = sin_bam(in_joint2_angle + 16'd16384);
    st1_nxt.w12  = 32'(in_joint1_rate) * 32'(in_joint2_rate);
    st1_nxt.w11  = 32'(in_joint1_rate) * 32'(in_joint1_rate);
    st1_nxt.ll   = 32'(link2_length_r) * 32'(link2_length_r);
    st1_nxt.lg   = 32'(link2_length_r) * 32'(gravity_r);
    st1_nxt.xx   = xx_full[30:0];
  end

  // --------------------------------------------------------------------------
  // Stage 2: scale by the link masses
  // --------------------------------------------------------------------------
  always_comb begin
    st2_nxt.sin2 = st1_r.sin2;
    st2_nxt.cos2 = st1_r.cos2;
    st2_nxt.cos1 = st1_r.cos1;
    st2_nxt.w12  = st1_r.w12;
    st2_nxt.w11  = st1_r.w11;
    st2_nxt.aex  = 48'(st1_r.ll) * 48'(link2_mass_r);
    st2_nxt.lgm  = 48'(st1_r.lg) * 48'(link2_mass_r);
    st2_nxt.t2   = 47'(link1_mass_r) * 47'(st1_r.xx);
  end

  // --------------------------------------------------------------------------
  // Stage 3: apply the trig terms, finish inertia_11
  // --------------------------------------------------------------------------
  always_comb begin
    a_r          = st2_r.aex[47:8];
    cos2_bias    = 18'(st2_r.cos2) + 18'd65536;
    i11_sum      = 49'(st2_r.aex) + 49'h80_0000;
    st3_nxt.t1   = 58'(a_r) * 58'(cos2_bias);
    st3_nxt.bs   = 59'($signed({1'b0, a_r})) * 59'(st2_r.sin2);
    st3_nxt.grav = 59'($signed({1'b0, st2_r.lgm[47:8]})) * 59'(st2_r.cos1);
    st3_nxt.t2   = st2_r.t2;
    st3_nxt.i11  = sat32(SAT_IN_W'(i11_sum[48:24]));
    st3_nxt.w12  = st2_r.w12;
    st3_nxt.w11  = st2_r.w11;
  end

  // --------------------------------------------------------------------------
  // Stage 4: finish inertia_00, round L^2*m2*sin to Q.24
  // --------------------------------------------------------------------------
  always_comb begin
    i00_sum      = 59'(st3_r.t1[57:1]) + 59'({st3_r.t2, 8'd0}) + 59'h8000_0000;
    // half away from zero: add half, less one for negative values
    bs_rnd       = st3_r.bs + 59'h80_0000 - 59'(st3_r.bs[58]);
    st4_nxt.i00  = sat32(SAT_IN_W'(i00_sum[58:32]));
    st4_nxt.i11  = st3_r.i11;
    st4_nxt.b24  = $signed(bs_rnd[57:24]);
    st4_nxt.grav = st3_r.grav;
    st4_nxt.w12  = st3_r.w12;
    st4_nxt.w11  = st3_r.w11;
  end

  // --------------------------------------------------------------------------
  // Stage 5: multiply by the rate products
  // --------------------------------------------------------------------------
  always_comb begin
    st5_nxt.i00  = st4_r.i00;
    st5_nxt.i11  = st4_r.i11;
    st5_nxt.p2   = 64'(st4_r.b24) * 64'(st4_r.w12);
    st5_nxt.p3   = 64'(st4_r.b24) * 64'(st4_r.w11);
    st5_nxt.grav = st4_r.grav;
  end

  // --------------------------------------------------------------------------
  // Stage 6: round the joint-one term, add gravity for joint two
  // --------------------------------------------------------------------------
  always_comb begin
    r2_rnd       = st5_r.p2 + 64'h80_0000 - 64'(st5_r.p2[63]);
    st6_nxt.i00  = st5_r.i00;
    st6_nxt.i11  = st5_r.i11;
    st6_nxt.r2   = $signed(r2_rnd[63:24]);
    st6_nxt.sum3 = st5_r.p3 + $signed({{4{st5_r.grav[58]}}, st5_r.grav, 1'b0});
  end

  // --------------------------------------------------------------------------
  // Stage 7: final rounding and saturation into the output register
  // --------------------------------------------------------------------------
  always_comb begin
    r3_rnd      = st6_r.sum3 + 64'h100_0000 - 64'(st6_r.sum3[63]);
    st7_nxt.i00 = st6_r.i00;
    st7_nxt.i11 = st6_r.i11;
    st7_nxt.tq1 = sat32(-st6_r.r2);
    st7_nxt.tq2 = sat32($signed({r3_rnd[63], r3_rnd[63:25]}));
  end

  // Hold each stage's payload unless the stage advances
  always_ff @(posedge clk) begin
    if (stg_en[0]) begin
      st1_r <= st1_nxt;
    end
    if (stg_en[1]) begin
      st2_r <= st2_nxt;
    end
    if (stg_en[2]) begin
      st3_r <= st3_nxt;
    end
    if (stg_en[3]) begin
      st4_r <= st4_nxt;
    end
    if (stg_en[4]) begin
      st5_r <= st5_nxt;
    end
    if (stg_en[5]) begin
      st6_r <= st6_nxt;
    end
    if (stg_en[6]) begin
      st7_r <= st7_nxt;
    end
  end

  // Drive the result channel
  assign out_valid         = vld_r[NSTG-1];
  assign out_inertia_00    = st7_r.i00;
  assign out_inertia_11    = st7_r.i11;
  assign out_torque_joint1 = st7_r.tq1;
  assign out_torque_joint2 = st7_r.tq2;

endmodule

[sv/tlad_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tlad_checker
// Port-level checks for the two-link arm dynamics block, bound to the top.
// ----------------------------------------------------------------------------
module tlad_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] out_inertia_00,
  input logic signed [31:0] out_inertia_11,
  input logic signed [31:0] out_torque_joint1,
  input logic signed [31:0] out_torque_joint2
);

  // Reset empties the pipeline
  a_rst_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A taken output frees every stage, so the input side must be open
  a_ready_flow: assert property (@(posedge clk) out_ready |-> in_ready)
    else $error("input blocked while output drains");

  // Inertia entries are sums of non-negative terms
  a_inertia_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !out_inertia_00[31] && !out_inertia_11[31])
    else $error("negative inertia entry");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_inertia_00)
      && $stable(out_inertia_11) && $stable(out_torque_joint1)
      && $stable(out_torque_joint2))
    else $error("stalled result changed");

endmodule

bind two_link_arm_dynamics_top tlad_checker u_tlad_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for two_link_arm_dynamics_top. A directed table walks
// the angle quadrants, rate extremes and saturating settings. Random phases
// with fresh register settings follow. Every accepted sample is run through a
// local fixed-point model of the arm terms, and each result transfer is
// compared field by field against the oldest pending prediction. Both
// handshake sides take random stalls, and one long output stall backs the
// pipeline up into the input.
// ----------------------------------------------------------------------------
module tb;
  import tlad_pkg::*;

  // Run shape
  localparam int          RANDOM_PHASES   = 5;
  localparam int          PHASE_SAMPLES   = 110;
  localparam int          SETTLE_CYCLES   = 12;
  localparam int          SQUEEZE_AT      = 200;
  localparam int          SQUEEZE_CYCLES  = 120;
  localparam int          REPORT_LIMIT    = 10;
  localparam logic [15:0] QUARTER_TURN    = 16'h4000;

  // Q16.16 saturation bounds
  localparam longint      Q16_HI  = 64'sd2147483647;
  localparam longint      Q16_LO  = -64'sd2147483648;
  localparam logic [31:0] SAT_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_NEG = 32'h8000_0000;

  // Fields of a row whose value is typed into the table
  localparam logic [3:0] KNOWN_NONE    = 4'b0000;
  localparam logic [3:0] KNOWN_TORQUES = 4'b1100;
  localparam logic [3:0] KNOWN_ALL     = 4'b1111;

  typedef struct packed {
    logic signed [31:0] inertia_00;
    logic signed [31:0] inertia_11;
    logic signed [31:0] torque_joint1;
    logic signed [31:0] torque_joint2;
  } arm_terms_t;

  // Register setting to load before a directed row
  typedef enum logic [1:0] {
    SETUP_KEEP,
    SETUP_ZERO,
    SETUP_INERTIA_ONLY,
    SETUP_MAX
  } setup_t;

  typedef struct packed {
    setup_t      setup;
    logic [15:0] angle;
    logic [15:0] rate1;
    logic [15:0] rate2;
    logic [3:0]  known;
    arm_terms_t  fixed;
  } stim_row_t;

  localparam arm_terms_t NO_TERMS   = '0;
  localparam arm_terms_t MASS_TERMS = '{32'sd4194240, 32'sd0, 32'sd0, 32'sd0};
  localparam arm_terms_t SAT_NP     = '{32'sd0, 32'sd0, SAT_NEG, SAT_POS};
  localparam arm_terms_t SAT_PP     = '{32'sd0, 32'sd0, SAT_POS, SAT_POS};
  localparam arm_terms_t SAT_PN     = '{32'sd0, 32'sd0, SAT_POS, SAT_NEG};

  localparam int DIRECTED_COUNT = 19;
  localparam stim_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    // reset register values: quadrant boundaries and rate extremes
    '{SETUP_KEEP,         16'h0000, 16'h0000, 16'h0000, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'h4000, 16'h7FFF, 16'h7FFF, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'h8000, 16'h8000, 16'h8000, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'hC000, 16'h7FFF, 16'h8000, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'hFFFF, 16'h0001, 16'hFFFF, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'h2000, 16'h0100, 16'h0100, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'h6000, 16'hFF00, 16'h0200, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'hE000, 16'h3039, 16'hEF1F, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'h0001, 16'hFFFF, 16'hFFFF, KNOWN_NONE,    NO_TERMS},
    // all registers zero: every term vanishes
    '{SETUP_ZERO,         16'h2000, 16'h7FFF, 16'h8000, KNOWN_ALL,     NO_TERMS},
    '{SETUP_KEEP,         16'hFFFF, 16'h8000, 16'h8000, KNOWN_ALL,     NO_TERMS},
    // only the link-1 mass and offset: inertia_00 = m1 * x^2
    '{SETUP_INERTIA_ONLY, 16'h0000, 16'h7FFF, 16'h7FFF, KNOWN_ALL,     MASS_TERMS},
    '{SETUP_KEEP,         16'h9000, 16'h8000, 16'h0001, KNOWN_ALL,     MASS_TERMS},
    // all registers at the top: torques saturate
    '{SETUP_MAX,          16'h2000, 16'h8000, 16'h8000, KNOWN_TORQUES, SAT_NP},
    '{SETUP_KEEP,         16'hA000, 16'h7FFF, 16'h8000, KNOWN_TORQUES, SAT_PP},
    '{SETUP_KEEP,         16'h6000, 16'h7FFF, 16'h7FFF, KNOWN_TORQUES, SAT_PN},
    '{SETUP_KEEP,         16'h0000, 16'h7FFF, 16'h7FFF, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'h4000, 16'h0000, 16'h0000, KNOWN_NONE,    NO_TERMS},
    '{SETUP_KEEP,         16'hFFFF, 16'h8000, 16'h7FFF, KNOWN_NONE,    NO_TERMS}
  };

  logic                        clk;
  logic                        rst_n;
  logic                        in_valid;
  logic                        in_ready;
  logic        [15:0]          in_joint2_angle;
  logic signed [15:0]          in_joint1_rate;
  logic signed [15:0]          in_joint2_rate;
  logic                        out_valid;
  logic                        out_ready = 1'b0;
  logic signed [31:0]          out_inertia_00;
  logic signed [31:0]          out_inertia_11;
  logic signed [31:0]          out_torque_joint1;
  logic signed [31:0]          out_torque_joint2;
  logic                        cfg_we;
  logic        [CFG_IDX_W-1:0] cfg_addr;
  logic        [15:0]          cfg_wdata;

  // Shadow copy of the configuration registers
  logic [15:0] arm_len   = RST_LINK2_LENGTH;
  logic [15:0] arm_m1    = RST_LINK1_MASS;
  logic [15:0] arm_m2    = RST_LINK2_MASS;
  logic [15:0] arm_xoff  = RST_LINK1_COM_OFFSET;
  logic [15:0] arm_grav  = RST_GRAVITY;

  longint     quarter_sine [SINE_DEPTH + 1];
  arm_terms_t expected_terms [$];
  bit         idle_on = 1'b1;
  bit         squeeze_done = 1'b0;
  int         n_errors = 0;
  int         n_results = 0;
  int         stall_left = 0;
  arm_terms_t got_terms;
  arm_terms_t want_terms;

  two_link_arm_dynamics_top DUT (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_joint2_angle   (in_joint2_angle),
    .in_joint1_rate    (in_joint1_rate),
    .in_joint2_rate    (in_joint2_rate),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_inertia_00    (out_inertia_00),
    .out_inertia_11    (out_inertia_11),
    .out_torque_joint1 (out_torque_joint1),
    .out_torque_joint2 (out_torque_joint2),
    .cfg_we            (cfg_we),
    .cfg_addr          (cfg_addr),
    .cfg_wdata         (cfg_wdata)
  );

  // 250 MHz clock
  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  // Sine of k quarter-table steps: odd series through x^11 in Q2.30, Q1.16 out
  function automatic longint taylor_sine_q16(input int k);
    longint unsigned x, x2, t, s;
    x  = (64'(k) * HALF_PI_Q30) / SINE_DEPTH;
    x2 = (x * x) >> 30;
    t  = ONE_Q30 - x2 / 110;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 72;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 42;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 20;
    t  = ONE_Q30 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd8192) >> 14;
    if (s > 64'd65536) begin
      s = 64'd65536;
    end
    return longint'(s);
  endfunction

  // Signed Q1.16 sine of a binary angle through the quarter-wave table
  function automatic longint wave_sine(input logic [15:0] a);
    logic [14:0] p;
    int          idx;
    longint      v;
    p = {1'b0, a[13:0]};
    if (a[14]) begin
      p = 15'd16384 - p;
    end
    idx = (int'(p) * SINE_DEPTH) >> 14;
    v   = quarter_sine[idx];
    return a[15] ? -v : v;
  endfunction

  // Shift right by s with rounding half away from zero
  function automatic longint round_shift(input longint v, input int s);
    longint m;
    m = (v < 0) ? -v : v;
    m = (m + (64'sd1 <<< (s - 1))) >>> s;
    return (v < 0) ? -m : m;
  endfunction

  function automatic logic [31:0] clamp_q16(input longint v);
    if (v > Q16_HI) begin
      return SAT_POS;
    end else if (v < Q16_LO) begin
      return SAT_NEG;
    end
    return v[31:0];
  endfunction

  // Mass-matrix diagonal and nonlinear torques for one sample
  function automatic arm_terms_t compute_arm_terms(input logic [15:0] ang,
                                                   input logic [15:0] rate1,
                                                   input logic [15:0] rate2);
    arm_terms_t  r;
    logic [15:0] dbl;
    longint      s2, c2, c1, len, m1, m2, g, x, w1, w2;
    longint      a_ex, a_r, t1, t2, b24, lgm, grav;
    dbl  = ang << 1;
    s2   = wave_sine(dbl);
    c2   = wave_sine(dbl + QUARTER_TURN);
    c1   = wave_sine(ang + QUARTER_TURN);
    len  = longint'(arm_len);
    m1   = longint'(arm_m1);
    m2   = longint'(arm_m2);
    g    = longint'(arm_grav);
    x    = longint'($signed(arm_xoff));
    w1   = longint'($signed(rate1));
    w2   = longint'($signed(rate2));
    // L^2*m2 in Q.40, truncated to Q.32 for the product terms
    a_ex = len * len * m2;
    a_r  = a_ex >>> 8;
    t1   = (a_r * (65536 + c2)) >>> 1;
    t2   = (m1 * (x * x)) <<< 8;
    r.inertia_00    = clamp_q16((t1 + t2 + 64'sh8000_0000) >>> 32);
    r.inertia_11    = clamp_q16((a_ex + 64'sh80_0000) >>> 24);
    b24  = round_shift(a_r * s2, 24);
    r.torque_joint1 = clamp_q16(round_shift(-(b24 * (w1 * w2)), 24));
    // gravity term: L*g*m2 in Q.24 times cos th2
    lgm  = (len * g * m2) >>> 8;
    grav = lgm * c1;
    r.torque_joint2 = clamp_q16(round_shift(b24 * (w1 * w1) + 2 * grav, 25));
    return r;
  endfunction

  // Register value with the extremes weighted in
  function automatic logic [15:0] pick_reg();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h8000;
      3:       return 16'h7FFF;
      default: return 16'($urandom);
    endcase
  endfunction

  function automatic logic [15:0] pick_angle();
    logic [1:0] q;
    q = 2'($urandom_range(0, 3));
    if ($urandom_range(0, 7) == 0) begin
      // land on or next to a quadrant boundary
      return {q, 14'd0} + 16'($urandom_range(0, 2)) - 16'd1;
    end
    return 16'($urandom);
  endfunction

  function automatic logic [15:0] pick_rate();
    case ($urandom_range(0, 7))
      0:       return 16'h8000;
      1:       return 16'h7FFF;
      2:       return 16'($urandom_range(0, 1023)) - 16'd512;
      default: return 16'($urandom);
    endcase
  endfunction

  // Write one register and track it in the shadow copy
  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_LINK2_LENGTH:     arm_len  = val;
      CFG_LINK1_MASS:       arm_m1   = val;
      CFG_LINK2_MASS:       arm_m2   = val;
      CFG_LINK1_COM_OFFSET: arm_xoff = val;
      CFG_GRAVITY:          arm_grav = val;
      default: ;
    endcase
  endtask

  // Load all five registers, then poke an unmapped index that must be dropped
  task automatic load_config(input logic [15:0] len, input logic [15:0] m1,
                             input logic [15:0] m2, input logic [15:0] xoff,
                             input logic [15:0] grav);
    int spare_idx;
    spare_idx = $urandom_range(int'(CFG_GRAVITY) + 1, (1 << CFG_IDX_W) - 1);
    cfg_write(CFG_LINK2_LENGTH, len);
    cfg_write(CFG_LINK1_MASS, m1);
    cfg_write(CFG_LINK2_MASS, m2);
    cfg_write(CFG_LINK1_COM_OFFSET, xoff);
    cfg_write(CFG_GRAVITY, grav);
    cfg_write(CFG_IDX_W'(spare_idx), 16'($urandom));
    cfg_we <= 1'b0;
  endtask

  // Hold the input, wait for all results, then let the pipeline go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (expected_terms.size() != 0) begin
      @(posedge clk);
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Offer one sample until it transfers; record its prediction
  task automatic send_sample(input logic [15:0] ang, input logic [15:0] rate1,
                             input logic [15:0] rate2, input arm_terms_t want);
    in_valid        <= 1'b1;
    in_joint2_angle <= ang;
    in_joint1_rate  <= rate1;
    in_joint2_rate  <= rate2;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    expected_terms.push_back(want);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  // Result side: check each transfer, then pick the next ready level
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        got_terms = '{out_inertia_00, out_inertia_11, out_torque_joint1,
                      out_torque_joint2};
        if (expected_terms.size() == 0) begin
          n_errors++;
          if (n_errors <= REPORT_LIMIT) begin
            $display("unexpected result %0d: %h %h %h %h", n_results,
                     got_terms.inertia_00, got_terms.inertia_11,
                     got_terms.torque_joint1, got_terms.torque_joint2);
          end
        end else begin
          want_terms = expected_terms.pop_front();
          if (got_terms !== want_terms) begin
            n_errors++;
            if (n_errors <= REPORT_LIMIT) begin
              $display("result %0d mismatch: expected %h %h %h %h, got %h %h %h %h",
                       n_results, want_terms.inertia_00, want_terms.inertia_11,
                       want_terms.torque_joint1, want_terms.torque_joint2,
                       got_terms.inertia_00, got_terms.inertia_11,
                       got_terms.torque_joint1, got_terms.torque_joint2);
            end
          end
        end
        n_results++;
      end
      // stall bursts, plus one long hold to back the pipeline up
      if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!squeeze_done && n_results >= SQUEEZE_AT) begin
        squeeze_done = 1'b1;
        stall_left   = SQUEEZE_CYCLES - 1;
        out_ready   <= 1'b0;
      end else if (idle_on && $urandom_range(0, 5) == 0) begin
        stall_left = $urandom_range(1, 13) - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Stimulus
  initial begin
    arm_terms_t  want;
    logic [15:0] ang, rate1, rate2;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      quarter_sine[k] = taylor_sine_q16(k);
    end
    rst_n           = 1'b0;
    in_valid        = 1'b0;
    in_joint2_angle = '0;
    in_joint1_rate  = '0;
    in_joint2_rate  = '0;
    cfg_we          = 1'b0;
    cfg_addr        = '0;
    cfg_wdata       = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table
    for (int i = 0; i < DIRECTED_COUNT; i++) begin
      if (DIRECTED_ROWS[i].setup != SETUP_KEEP) begin
        settle();
        case (DIRECTED_ROWS[i].setup)
          SETUP_ZERO:
            load_config(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
          SETUP_INERTIA_ONLY:
            load_config(16'h0000, 16'hFFFF, 16'h0000, 16'h8000, 16'h0000);
          default:
            load_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h7FFF, 16'hFFFF);
        endcase
      end
      want = compute_arm_terms(DIRECTED_ROWS[i].angle, DIRECTED_ROWS[i].rate1,
                               DIRECTED_ROWS[i].rate2);
      if (DIRECTED_ROWS[i].known[0]) want.inertia_00    = DIRECTED_ROWS[i].fixed.inertia_00;
      if (DIRECTED_ROWS[i].known[1]) want.inertia_11    = DIRECTED_ROWS[i].fixed.inertia_11;
      if (DIRECTED_ROWS[i].known[2]) want.torque_joint1 = DIRECTED_ROWS[i].fixed.torque_joint1;
      if (DIRECTED_ROWS[i].known[3]) want.torque_joint2 = DIRECTED_ROWS[i].fixed.torque_joint2;
      send_sample(DIRECTED_ROWS[i].angle, DIRECTED_ROWS[i].rate1,
                  DIRECTED_ROWS[i].rate2, want);
    end

    // Random phases, each with its own register setting; last one runs flat out
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      settle();
      load_config(pick_reg(), pick_reg(), pick_reg(), pick_reg(), pick_reg());
      idle_on = (phase != RANDOM_PHASES - 1);
      repeat (PHASE_SAMPLES) begin
        ang   = pick_angle();
        rate1 = pick_rate();
        rate2 = pick_rate();
        send_sample(ang, rate1, rate2, compute_arm_terms(ang, rate1, rate2));
      end
    end

    settle();
    if (n_errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

endmodule
